// ===== rtl/tdc_pkg.sv =====
// Package for the touch debounce and calibration block.
// Holds shared widths, register indexes, reset values and the control structs.
// No dependencies.
`default_nettype none

package tdc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int ZONE_W      = 2 * SAMPLE_BITS;
    localparam int ORIENT_W    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int STEP_W      = $clog2(SAMPLE_BITS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_X_RAW_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_RAW_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RAW_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RAW_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_RES       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RES       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION = 3'd7;

    // Register values after reset.
    localparam logic [SAMPLE_BITS-1:0] RST_RAW_MIN   = 12'd200;
    localparam logic [SAMPLE_BITS-1:0] RST_RAW_MAX   = 12'd3900;
    localparam logic [SAMPLE_BITS-1:0] RST_X_RES     = 12'd320;
    localparam logic [SAMPLE_BITS-1:0] RST_Y_RES     = 12'd240;
    localparam logic [SAMPLE_BITS-1:0] RST_TOLERANCE = 12'd20;
    localparam logic [ORIENT_W-1:0]    RST_ORIENT    = 3'd1;

    // Orientation bits.
    localparam int OR_DIRECT = 0;
    localparam int OR_FLIP_X = 1;
    localparam int OR_FLIP_Y = 2;

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic load_in;
        logic check;
        logic mul_go;
        logic mul_y;
        logic div_init;
        logic div_step;
        logic store_x;
        logic orient;
        logic zmul;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic ok;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/tdc_in_if.sv =====
// Request channel of the touch block: three raw readings per axis.
// Depends on tdc_pkg.
`default_nettype none

interface tdc_in_if
    import tdc_pkg::*;
;
    logic    valid;
    logic    ready;
    t_sample first_x;
    t_sample first_y;
    t_sample second_x;
    t_sample second_y;
    t_sample third_x;
    t_sample third_y;

    modport source (
        output valid, first_x, first_y, second_x, second_y, third_x, third_y,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, second_x, second_y, third_x, third_y,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/tdc_out_if.sv =====
// Result channel of the touch block: press flag, pixel position and zone.
// Depends on tdc_pkg.
`default_nettype none

interface tdc_out_if
    import tdc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              pressed;
    t_sample           pixel_x;
    t_sample           pixel_y;
    logic [ZONE_W-1:0] zone;
    t_sample           latched_raw_x;
    t_sample           latched_raw_y;

    modport source (
        output valid, pressed, pixel_x, pixel_y, zone, latched_raw_x, latched_raw_y,
        input  ready
    );
    modport sink (
        input  valid, pressed, pixel_x, pixel_y, zone, latched_raw_x, latched_raw_y,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/touch_debounce_calibrate_top.sv =====
// Accepted touch: 12 divider steps per axis on one shared restoring divider and a 12x12
// multiplier shared by both axes; the zone product has a multiplier of its own.
// Rejected touch: no scaling. A new request is taken once the last result is loaded.
// A finished result waits in an output register while the next request is taken.
// Synchronous active-low reset loads the register defaults and clears the held position.
// Top level: joins tdc_ctrl and tdc_dp; depends on tdc_pkg, tdc_in_if and tdc_out_if.
`default_nettype none

module touch_debounce_calibrate_top
    import tdc_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    tdc_in_if.sink                i_req,
    tdc_out_if.source             o_res,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [SAMPLE_BITS-1:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    tdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tdc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_first_x       (i_req.first_x),
        .i_first_y       (i_req.first_y),
        .i_second_x      (i_req.second_x),
        .i_second_y      (i_req.second_y),
        .i_third_x       (i_req.third_x),
        .i_third_y       (i_req.third_y),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_pressed       (o_res.pressed),
        .o_pixel_x       (o_res.pixel_x),
        .o_pixel_y       (o_res.pixel_y),
        .o_zone          (o_res.zone),
        .o_latched_raw_x (o_res.latched_raw_x),
        .o_latched_raw_y (o_res.latched_raw_y)
    );

endmodule

`default_nettype wire

// ===== rtl/tdc_ctrl.sv =====
// Sequencer of the touch block: steps the datapath through check, scale,
// orientation and zone, and owns the request and result handshakes. Depends on tdc_pkg.
`default_nettype none

module tdc_ctrl
    import tdc_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  wire   i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_MULX   = 4'd2;
    localparam logic [3:0] S_DINX   = 4'd3;
    localparam logic [3:0] S_DIVX   = 4'd4;
    localparam logic [3:0] S_MULY   = 4'd5;
    localparam logic [3:0] S_DINY   = 4'd6;
    localparam logic [3:0] S_DIVY   = 4'd7;
    localparam logic [3:0] S_ORIENT = 4'd8;
    localparam logic [3:0] S_ZMUL   = 4'd9;
    localparam logic [3:0] S_ZOUT   = 4'd10;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SAMPLE_BITS - 1);

    logic [3:0]        r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic              w_in_fire;
    logic              w_out_free;
    t_cmd              w_cmd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;
    assign w_in_fire   = i_in_valid && o_in_ready;
    // The output register may be reloaded in the cycle its request is taken.
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                w_cmd.load_in = w_in_fire;
                if (w_in_fire) n_state = S_CHECK;
            end
            S_CHECK: begin
                w_cmd.check = 1'b1;
                n_state     = i_stat.ok ? S_MULX : S_ZMUL;
            end
            S_MULX: begin
                w_cmd.mul_go = 1'b1;
                n_state      = S_DINX;
            end
            S_DINX: begin
                w_cmd.div_init = 1'b1;
                n_state        = S_DIVX;
            end
            S_DIVX: begin
                w_cmd.div_step = 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_cnt   = '0;
                    n_state = S_MULY;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MULY: begin
                w_cmd.mul_go  = 1'b1;
                w_cmd.mul_y   = 1'b1;
                w_cmd.store_x = 1'b1;
                n_state       = S_DINY;
            end
            S_DINY: begin
                w_cmd.div_init = 1'b1;
                n_state        = S_DIVY;
            end
            S_DIVY: begin
                w_cmd.div_step = 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_cnt   = '0;
                    n_state = S_ORIENT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ORIENT: begin
                w_cmd.orient = 1'b1;
                n_state      = S_ZMUL;
            end
            S_ZMUL: begin
                w_cmd.zmul = 1'b1;
                n_state    = S_ZOUT;
            end
            S_ZOUT: begin
                if (w_out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register reloaded while its request was pending");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIVX && r_state != S_DIVY) |-> (r_cnt == '0))
        else $error("division step counter active outside a division");

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == S_CHECK))
        else $error("accepted request did not start its check");

    a_out_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_ZOUT))
        else $error("result appeared without a load");
`endif

endmodule

`default_nettype wire

// ===== rtl/tdc_dp.sv =====
// Datapath of the touch block: configuration registers, input latch,
// debounce check, shared multiplier, restoring divider and result register.
// Depends on tdc_pkg.
`default_nettype none

module tdc_dp
    import tdc_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [SAMPLE_BITS-1:0] i_cfg_data,
    input  t_sample               i_first_x,
    input  t_sample               i_first_y,
    input  t_sample               i_second_x,
    input  t_sample               i_second_y,
    input  t_sample               i_third_x,
    input  t_sample               i_third_y,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic                  o_pressed,
    output t_sample               o_pixel_x,
    output t_sample               o_pixel_y,
    output logic [ZONE_W-1:0]     o_zone,
    output t_sample               o_latched_raw_x,
    output t_sample               o_latched_raw_y
);

    // Configuration registers.
    t_sample             r_xmin, r_xmax, r_ymin, r_ymax, r_xres, r_yres, r_tol;
    logic [ORIENT_W-1:0] r_orient;

    // Latched readings.
    t_sample r_fx, r_fy, r_sx, r_sy, r_tx, r_ty;

    // Working registers.
    logic              r_ok;
    logic [ZONE_W-1:0] r_prod;
    t_sample           r_den, r_rem, r_quo, r_ax;
    t_sample           r_held_x, r_held_y;
    logic [ZONE_W-1:0] r_zprod;

    // Result register.
    logic              r_o_pressed;
    t_sample           r_o_px, r_o_py, r_o_rx, r_o_ry;
    logic [ZONE_W-1:0] r_o_zone;

    function automatic logic close_to(t_sample a, t_sample b, t_sample tol);
        t_sample d;
        d = (a > b) ? (a - b) : (b - a);
        return d <= tol;
    endfunction

    function automatic t_sample clamp(t_sample q, t_sample res);
        return (q > res) ? res : q;
    endfunction

    logic                 w_ok;
    t_sample              w_mul_a, w_mul_b;
    logic [ZONE_W-1:0]    w_prod;
    logic [SAMPLE_BITS:0] w_trial, w_diff;
    logic                 w_ge;
    t_sample              w_ay, w_px, w_py;

    assign w_ok = close_to(r_fx, r_sx, r_tol) && close_to(r_fy, r_sy, r_tol) &&
                  close_to(r_fx, r_tx, r_tol) && close_to(r_fy, r_ty, r_tol) &&
                  (r_fy > r_ymin) && (r_fy < r_ymax) &&
                  (r_fx > r_xmin) && (r_fx < r_xmax);
    assign o_stat.ok = w_ok;

    assign w_mul_a = i_cmd.mul_y ? (r_fy - r_ymin) : (r_fx - r_xmin);
    assign w_mul_b = i_cmd.mul_y ? r_yres : r_xres;
    assign w_prod  = ZONE_W'(w_mul_a) * ZONE_W'(w_mul_b);

    // One restoring step: the remainder stays below the divisor, so the
    // trial value fits one bit above the sample width.
    assign w_trial = {r_rem, r_quo[SAMPLE_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    assign w_ay = clamp(r_quo, r_yres);

    always_comb begin
        if (!r_orient[OR_DIRECT]) begin
            w_px = r_orient[OR_FLIP_X] ? (r_yres - w_ay) : w_ay;
            w_py = r_orient[OR_FLIP_Y] ? (r_xres - r_ax) : r_ax;
        end else begin
            w_px = r_orient[OR_FLIP_X] ? (r_xres - r_ax) : r_ax;
            w_py = r_orient[OR_FLIP_Y] ? (r_yres - w_ay) : w_ay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xmin   <= RST_RAW_MIN;
            r_xmax   <= RST_RAW_MAX;
            r_ymin   <= RST_RAW_MIN;
            r_ymax   <= RST_RAW_MAX;
            r_xres   <= RST_X_RES;
            r_yres   <= RST_Y_RES;
            r_tol    <= RST_TOLERANCE;
            r_orient <= RST_ORIENT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_X_RAW_MIN:   r_xmin   <= i_cfg_data;
                CFG_X_RAW_MAX:   r_xmax   <= i_cfg_data;
                CFG_Y_RAW_MIN:   r_ymin   <= i_cfg_data;
                CFG_Y_RAW_MAX:   r_ymax   <= i_cfg_data;
                CFG_X_RES:       r_xres   <= i_cfg_data;
                CFG_Y_RES:       r_yres   <= i_cfg_data;
                CFG_TOLERANCE:   r_tol    <= i_cfg_data;
                CFG_ORIENTATION: r_orient <= i_cfg_data[ORIENT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x <= '0;
            r_held_y <= '0;
        end else if (i_cmd.orient) begin
            r_held_x <= w_px;
            r_held_y <= w_py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_fx <= i_first_x;
            r_fy <= i_first_y;
            r_sx <= i_second_x;
            r_sy <= i_second_y;
            r_tx <= i_third_x;
            r_ty <= i_third_y;
        end
        if (i_cmd.check) r_ok <= w_ok;
        if (i_cmd.mul_go) begin
            r_prod <= w_prod;
            r_den  <= i_cmd.mul_y ? (r_ymax - r_ymin) : (r_xmax - r_xmin);
        end
        if (i_cmd.store_x) r_ax <= clamp(r_quo, r_xres);
        if (i_cmd.div_init) begin
            // The quotient is below the resolution, so the upper half of the
            // dividend already sits below the divisor.
            r_rem <= r_prod[ZONE_W-1:SAMPLE_BITS];
            r_quo <= r_prod[SAMPLE_BITS-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[SAMPLE_BITS-1:0] : w_trial[SAMPLE_BITS-1:0];
            r_quo <= {r_quo[SAMPLE_BITS-2:0], w_ge};
        end
        if (i_cmd.zmul) r_zprod <= ZONE_W'(r_held_y) * ZONE_W'(r_xres);
        if (i_cmd.out_load) begin
            r_o_pressed <= r_ok;
            r_o_px      <= r_held_x;
            r_o_py      <= r_held_y;
            r_o_zone    <= ZONE_W'(r_held_x) + r_zprod;
            r_o_rx      <= r_fx;
            r_o_ry      <= r_fy;
        end
    end

    assign o_pressed       = r_o_pressed;
    assign o_pixel_x       = r_o_px;
    assign o_pixel_y       = r_o_py;
    assign o_zone          = r_o_zone;
    assign o_latched_raw_x = r_o_rx;
    assign o_latched_raw_y = r_o_ry;

endmodule

`default_nettype wire

// ===== tb/sv/tdc_checker.sv =====
// Result checker for the touch debounce and calibration block.
// Mirrors the register writes, predicts each result from the accepted requests
// and compares it field by field. Depends on tdc_pkg, tdc_in_if and tdc_out_if.
`default_nettype none

module tdc_checker
    import tdc_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    tdc_in_if                     i_req,
    tdc_out_if                    i_res,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [SAMPLE_BITS-1:0] i_cfg_data,
    output int                    o_outstanding,
    output int                    o_errors
);

    typedef struct packed {
        logic              pressed;
        t_sample           pixel_x;
        t_sample           pixel_y;
        logic [ZONE_W-1:0] zone;
        t_sample           raw_x;
        t_sample           raw_y;
    } t_touch_result;

    t_touch_result       pending_q[$];
    int unsigned         x_min, x_max, y_min, y_max;
    int unsigned         x_res, y_res, tolerance;
    logic [ORIENT_W-1:0] orient;
    int unsigned         held_x, held_y;
    int                  mismatches = 0;
    int                  results_seen = 0;

    function automatic bit within_tol(input int unsigned a, input int unsigned b);
        return ((a > b) ? a - b : b - a) <= tolerance;
    endfunction

    // Only called for a reading strictly inside the window, so hi - lo is never zero.
    function automatic int unsigned to_pixels(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi, input int unsigned res);
        int unsigned q;
        q = ((v - lo) * res) / (hi - lo);
        return (q > res) ? res : q;
    endfunction

    function automatic t_touch_result predict_touch(
        input int unsigned fx, input int unsigned fy, input int unsigned sx,
        input int unsigned sy, input int unsigned tx, input int unsigned ty);
        t_touch_result r;
        int unsigned   ax, ay, px, py;
        bit            ok;
        ok = within_tol(fx, sx) && within_tol(fy, sy) && within_tol(fx, tx) &&
             within_tol(fy, ty) && fx > x_min && fx < x_max && fy > y_min && fy < y_max;
        if (ok) begin
            ax = to_pixels(fx, x_min, x_max, x_res);
            ay = to_pixels(fy, y_min, y_max, y_res);
            if (orient[OR_DIRECT]) begin
                px = orient[OR_FLIP_X] ? x_res - ax : ax;
                py = orient[OR_FLIP_Y] ? y_res - ay : ay;
            end else begin
                // With swapped axes each flip mirrors against the scale its value came from.
                px = orient[OR_FLIP_X] ? y_res - ay : ay;
                py = orient[OR_FLIP_Y] ? x_res - ax : ax;
            end
            held_x = px & 32'hFFF;
            held_y = py & 32'hFFF;
        end
        r.pressed = ok;
        r.pixel_x = t_sample'(held_x);
        r.pixel_y = t_sample'(held_y);
        r.zone    = ZONE_W'(held_x + held_y * x_res);
        r.raw_x   = t_sample'(fx);
        r.raw_y   = t_sample'(fy);
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("Result %0d: %s expected %0d, got %0d", results_seen, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_touch_result want;
        if (!i_rst_n) begin
            x_min     = RST_RAW_MIN;
            x_max     = RST_RAW_MAX;
            y_min     = RST_RAW_MIN;
            y_max     = RST_RAW_MAX;
            x_res     = RST_X_RES;
            y_res     = RST_Y_RES;
            tolerance = RST_TOLERANCE;
            orient    = RST_ORIENT;
            held_x    = 0;
            held_y    = 0;
            pending_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_X_RAW_MIN:   x_min     = i_cfg_data;
                    CFG_X_RAW_MAX:   x_max     = i_cfg_data;
                    CFG_Y_RAW_MIN:   y_min     = i_cfg_data;
                    CFG_Y_RAW_MAX:   y_max     = i_cfg_data;
                    CFG_X_RES:       x_res     = i_cfg_data;
                    CFG_Y_RES:       y_res     = i_cfg_data;
                    CFG_TOLERANCE:   tolerance = i_cfg_data;
                    CFG_ORIENTATION: orient    = i_cfg_data[ORIENT_W-1:0];
                    default: ;
                endcase
            end
            // Results are retired before new requests are queued, since a result
            // never belongs to the request accepted at the same edge.
            if (i_res.valid && i_res.ready) begin
                if (pending_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("Result %0d arrived with no request waiting", results_seen);
                    mismatches++;
                end else begin
                    want = pending_q.pop_front();
                    check_field("pressed", want.pressed, i_res.pressed);
                    check_field("pixel_x", want.pixel_x, i_res.pixel_x);
                    check_field("pixel_y", want.pixel_y, i_res.pixel_y);
                    check_field("zone", want.zone, i_res.zone);
                    check_field("latched_raw_x", want.raw_x, i_res.latched_raw_x);
                    check_field("latched_raw_y", want.raw_y, i_res.latched_raw_y);
                end
                results_seen++;
            end
            if (i_req.valid && i_req.ready)
                pending_q.push_back(predict_touch(i_req.first_x, i_req.first_y,
                                                  i_req.second_x, i_req.second_y,
                                                  i_req.third_x, i_req.third_y));
        end
        o_outstanding <= pending_q.size();
        o_errors      <= mismatches;
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Top of the touch block testbench: clock, reset, register setup, requests and stall.
// Runs directed touches, then random phases under varied calibration and orientation.
// Depends on tdc_pkg, tdc_in_if, tdc_out_if, touch_debounce_calibrate_top and tdc_checker.
`default_nettype none

module tb_top;
    import tdc_pkg::*;

    localparam int PHASES     = 12;
    localparam int PHASE_LEN  = 170;
    localparam int SETTLE_CYC = 40;

    typedef struct packed {
        t_sample fx;
        t_sample fy;
        t_sample sx;
        t_sample sy;
        t_sample tx;
        t_sample ty;
    } t_touch;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [SAMPLE_BITS-1:0] cfg_data;
    int                     outstanding;
    int                     errors;
    bit                     tx_calm;
    bit                     rx_calm;
    int                     stall_left;
    int unsigned            win_x_lo, win_x_hi, win_y_lo, win_y_hi, win_tol;

    tdc_in_if  req_ch ();
    tdc_out_if res_ch ();

    touch_debounce_calibrate_top u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tdc_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_ch),
        .i_res         (res_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_outstanding (outstanding),
        .o_errors      (errors)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: after each taken result, ready may drop for a random stall; none while rx_calm is set.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
        end else if (res_ch.ready && res_ch.valid) begin
            stall_left = rx_calm ? 0 : $urandom_range(0, 9);
            res_ch.ready <= (stall_left == 0);
        end else if (!res_ch.ready) begin
            if (stall_left <= 1)
                res_ch.ready <= 1'b1;
            if (stall_left > 0)
                stall_left = stall_left - 1;
        end
    end

    function automatic t_touch touch_of(input int unsigned fx, input int unsigned fy,
                                        input int unsigned sx, input int unsigned sy,
                                        input int unsigned tx, input int unsigned ty);
        t_touch t;
        t.fx = t_sample'(fx);
        t.fy = t_sample'(fy);
        t.sx = t_sample'(sx);
        t.sy = t_sample'(sy);
        t.tx = t_sample'(tx);
        t.ty = t_sample'(ty);
        return t;
    endfunction

    function automatic t_sample near_reading(input int unsigned base, input int unsigned spread);
        int unsigned lo, hi;
        lo = (base > spread) ? base - spread : 0;
        hi = (base + spread > 4095) ? 4095 : base + spread;
        return t_sample'($urandom_range(hi, lo));
    endfunction

    function automatic t_sample offset_reading(input int unsigned base, input int unsigned dev);
        if ($urandom_range(0, 1) && base + dev <= 4095)
            return t_sample'(base + dev);
        if (base >= dev)
            return t_sample'(base - dev);
        return t_sample'((base + dev > 4095) ? 4095 : base + dev);
    endfunction

    // Mostly strictly inside the window, now and then right on or next to a bound.
    function automatic t_sample inside_reading(input int unsigned lo, input int unsigned hi);
        if (hi < lo + 2)
            return t_sample'($urandom_range(4095, 0));
        case ($urandom_range(0, 19))
            0:       return t_sample'(lo);
            1:       return t_sample'(lo + 1);
            2:       return t_sample'(hi - 1);
            3:       return t_sample'(hi);
            default: return t_sample'($urandom_range(hi - 1, lo + 1));
        endcase
    endfunction

    function automatic t_touch random_touch();
        t_touch      t;
        int unsigned pick, dev;
        pick = $urandom_range(0, 99);
        if (pick >= 85) begin
            t = touch_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            t.fx = inside_reading(win_x_lo, win_x_hi);
            t.fy = inside_reading(win_y_lo, win_y_hi);
            t.sx = near_reading(t.fx, win_tol);
            t.sy = near_reading(t.fy, win_tol);
            t.tx = near_reading(t.fx, win_tol);
            t.ty = near_reading(t.fy, win_tol);
            if (pick >= 70) begin
                // One repeated reading lands exactly on the tolerance or one past it.
                dev = win_tol + $urandom_range(0, 1);
                case ($urandom_range(0, 3))
                    0:       t.sx = offset_reading(t.fx, dev);
                    1:       t.sy = offset_reading(t.fy, dev);
                    2:       t.tx = offset_reading(t.fx, dev);
                    default: t.ty = offset_reading(t.fy, dev);
                endcase
            end
        end
        return t;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= t_sample'(value);
        @(posedge clk);
    endtask

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_touch(input t_touch t, input int gap);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.first_x  <= t.fx;
        req_ch.first_y  <= t.fy;
        req_ch.second_x <= t.sx;
        req_ch.second_y <= t.sy;
        req_ch.third_x  <= t.tx;
        req_ch.third_y  <= t.ty;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    initial begin : stimulus
        t_touch      directed[$];
        int unsigned lo_x, hi_x, lo_y, hi_y, res_x, res_y, tol;
        req_ch.valid    = 1'b0;
        req_ch.first_x  = '0;
        req_ch.first_y  = '0;
        req_ch.second_x = '0;
        req_ch.second_y = '0;
        req_ch.third_x  = '0;
        req_ch.third_y  = '0;
        res_ch.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        rst_n           = 1'b0;
        tx_calm         = 1'b0;
        rx_calm         = 1'b0;
        win_x_lo        = RST_RAW_MIN;
        win_x_hi        = RST_RAW_MAX;
        win_y_lo        = RST_RAW_MIN;
        win_y_hi        = RST_RAW_MAX;
        win_tol         = RST_TOLERANCE;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed touches under the reset calibration.
        directed.push_back(touch_of(0, 0, 0, 0, 0, 0));
        directed.push_back(touch_of(4095, 4095, 4095, 4095, 4095, 4095));
        directed.push_back(touch_of(2000, 2000, 2000, 2000, 2000, 2000));
        directed.push_back(touch_of(201, 201, 201, 201, 201, 201));
        directed.push_back(touch_of(3899, 3899, 3899, 3899, 3899, 3899));
        directed.push_back(touch_of(200, 1000, 200, 1000, 200, 1000));
        directed.push_back(touch_of(1000, 3900, 1000, 3900, 1000, 3900));
        directed.push_back(touch_of(2000, 2000, 2020, 2000, 2000, 2000));
        directed.push_back(touch_of(2000, 2000, 2021, 2000, 2000, 2000));
        directed.push_back(touch_of(2000, 2000, 2000, 1979, 2000, 2000));
        directed.push_back(touch_of(2000, 2000, 2000, 2000, 1979, 2000));
        directed.push_back(touch_of(2000, 2000, 2000, 2000, 2000, 2021));
        directed.push_back(touch_of(2000, 2000, 1980, 2020, 2020, 1980));
        directed.push_back(touch_of(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555));
        directed.push_back(touch_of(12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA));
        directed.push_back(touch_of(12'h555, 12'hAAA, 12'hAAA, 12'h555, 12'hFFF, 12'h000));
        foreach (directed[k])
            send_touch(directed[k], $urandom_range(0, 9));
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            lo_x  = $urandom_range(0, 2000);
            hi_x  = $urandom_range(4095, lo_x + 2);
            lo_y  = $urandom_range(0, 2000);
            hi_y  = $urandom_range(4095, lo_y + 2);
            res_x = $urandom_range(1, 4095);
            res_y = $urandom_range(1, 4095);
            tol   = $urandom_range(0, 100);
            case (phase)
                0: begin
                    lo_x  = 0;
                    hi_x  = 4095;
                    lo_y  = 0;
                    hi_y  = 4095;
                    res_x = 4095;
                    res_y = 4095;
                    tol   = 0;
                end
                1: begin
                    res_x = 1;
                    res_y = 1;
                    tol   = 4095;
                end
                2: begin
                    res_x = 0;
                    res_y = 0;
                end
                // An x window only one wide leaves no reading strictly inside it.
                3: hi_x = lo_x + 1;
                4: begin
                    lo_y = 4095;
                    hi_y = 0;
                end
                5: begin
                    lo_x = 4093;
                    hi_x = 4095;
                    lo_y = 0;
                    hi_y = 2;
                end
                default: ;
            endcase
            write_reg(CFG_X_RAW_MIN, lo_x);
            write_reg(CFG_X_RAW_MAX, hi_x);
            write_reg(CFG_Y_RAW_MIN, lo_y);
            write_reg(CFG_Y_RAW_MAX, hi_y);
            write_reg(CFG_X_RES, res_x);
            write_reg(CFG_Y_RES, res_y);
            write_reg(CFG_TOLERANCE, tol);
            write_reg(CFG_ORIENTATION, phase % 8);
            cfg_we   <= 1'b0;
            win_x_lo = lo_x;
            win_x_hi = hi_x;
            win_y_lo = lo_y;
            win_y_hi = hi_y;
            win_tol  = tol;

            for (int n = 0; n < PHASE_LEN; n++) begin
                if (n % 50 == 0) begin
                    tx_calm = ($urandom_range(0, 3) == 0);
                    rx_calm = ($urandom_range(0, 3) == 0);
                end
                send_touch(random_touch(), tx_calm ? 0 : $urandom_range(0, 9));
            end
            drain();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog
        #(20 * 600000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// ===== touch_debounce_calibrate_top.f =====
rtl/tdc_pkg.sv
rtl/tdc_in_if.sv
rtl/tdc_out_if.sv
rtl/tdc_ctrl.sv
rtl/tdc_dp.sv
rtl/touch_debounce_calibrate_top.sv
tb/sv/tdc_checker.sv
tb/sv/tb_top.sv
